FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the range min/max tree; used by rmm_back.
// Defining ASSERT_OFF compiles every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, ck, rn, prop, msg)
`define ASSERT_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

FILE: hw/rtl/rmm_pkg.sv
// Package for the range min/max tree: widths, codes, command and state types.
// No dependencies; used by every RTL file but rmm_ram and assert_macros.svh.
`default_nettype none
package rmm_pkg;

  localparam int IDX_W         = 11;
  localparam int VAL_W         = 31;
  localparam int MAX_ITEMS_DEF = 1024;
  localparam int Q_DEPTH       = 2;

  localparam logic [VAL_W-1:0] MIN_EMPTY      = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] MAX_EMPTY      = '0;
  localparam logic [IDX_W-1:0] ITEM_COUNT_RST = IDX_W'(1024);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_W-1:0]        n;
    logic [IDX_W-1:0]        first;
    logic [IDX_W-1:0]        last;
    logic [VAL_W-1:0]        value;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_LOAD,
    B_LOAD_END,
    B_QUERY,
    B_QDRAIN,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rmm_if.sv
// Channel interfaces of the range min/max tree: input, result and config.
// Depends on rmm_pkg for field widths.
`default_nettype none
interface rmm_in_if;
  import rmm_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] last_index;
  logic [VAL_W-1:0] value;
  modport source (output valid, mode, first_index, last_index, value, input ready);
  modport sink   (input valid, mode, first_index, last_index, value, output ready);
endinterface

interface rmm_out_if;
  import rmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] range_min;
  logic [VAL_W-1:0] range_max;
  modport source (output valid, range_min, range_max, input ready);
  modport sink   (input valid, range_min, range_max, output ready);
endinterface

interface rmm_cfg_if;
  import rmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rmm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module rmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rmm_front.sv
// Front end: accepts input transactions, saturates the span bound and sorts
// each item into load, query or empty query. Depends on rmm_pkg, rmm_if.
`default_nettype none
module rmm_front #(
  parameter int MAX_ITEMS = rmm_pkg::MAX_ITEMS_DEF
) (
  input  wire logic [rmm_pkg::IDX_W-1:0] item_count,
  input  wire logic                      clearing,
  rmm_in_if.sink                         in_chan,
  output logic                           push_valid,
  output rmm_pkg::cmd_t                  push_cmd,
  input  wire logic                      push_ready
);
  import rmm_pkg::*;

  logic [IDX_W-1:0] n;
  logic             accept;
  logic             drop;

  always_comb begin
    if (item_count == '0) begin
      n = IDX_W'(1);
    end else if (int'(item_count) > MAX_ITEMS) begin
      n = IDX_W'(MAX_ITEMS);
    end else begin
      n = item_count;
    end
  end

  assign in_chan.ready = !clearing && push_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    drop           = 1'b0;
    push_cmd.n     = n;
    push_cmd.first = in_chan.first_index;
    push_cmd.last  = in_chan.last_index;
    push_cmd.value = in_chan.value;
    if (in_chan.mode == MODE_LOAD) begin
      push_cmd.kind = CMD_LOAD;
      // loads off the span change nothing
      drop = (in_chan.first_index == '0) || (in_chan.first_index > n);
    end else if (in_chan.first_index > in_chan.last_index) begin
      push_cmd.kind = CMD_EMPTY;
    end else begin
      push_cmd.kind = CMD_QUERY;
    end
  end

  assign push_valid = accept && !drop;

endmodule
`default_nettype wire

FILE: hw/rtl/rmm_queue.sv
// Short command queue between the front end and the tree engine.
// Depends on rmm_pkg for the command type and depth.
`default_nettype none
module rmm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  rmm_pkg::cmd_t       push_data,
  output logic                push_ready,
  output logic                pop_valid,
  output rmm_pkg::cmd_t       pop_data,
  input  wire logic           pop_ready
);
  import rmm_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             q_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rmm_back.sv
// Tree engine: clears the node RAM after reset, folds loads along the
// root-to-leaf path and walks query ranges with a node stack.
// Depends on rmm_pkg, rmm_if, rmm_ram and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module rmm_back #(
  parameter int MAX_ITEMS = rmm_pkg::MAX_ITEMS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cmd_valid,
  input  rmm_pkg::cmd_t cmd,
  output logic         cmd_ready,
  output logic         clearing,
  rmm_out_if.source    out_chan
);
  import rmm_pkg::*;

  localparam int DEPTH       = 4 * MAX_ITEMS;
  localparam int NODE_W      = $clog2(DEPTH);
  localparam int STACK_DEPTH = NODE_W;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 2 * VAL_W;

  typedef struct packed {
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [NODE_W-1:0] node;
  } frame_t;

  back_state_t       state_r, state_nxt;
  logic [NODE_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]  l_r, l_nxt, r_r, r_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              pend_r, pend_nxt;
  logic [NODE_W-1:0] pend_node_r, pend_node_nxt;
  logic [VAL_W-1:0]  min_acc_r, min_acc_nxt, max_acc_r, max_acc_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt, sp_dec;
  frame_t            stk_r [STACK_DEPTH];
  frame_t            push_frame, top_frame;
  logic              push;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_min_r, out_min_nxt, out_max_r, out_max_nxt;

  logic              ram_we, ram_re;
  logic [NODE_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [VAL_W-1:0]  rd_max, rd_min, fold_max, fold_min;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid, mid_inc;
  logic [NODE_W-1:0] left_node, right_node;
  logic              disjoint, covered;

  // node word: max tree in the upper half, min tree in the lower half
  rmm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_max     = ram_rdata[WORD_W-1:VAL_W];
  assign rd_min     = ram_rdata[VAL_W-1:0];
  assign fold_max   = (val_r > rd_max) ? val_r : rd_max;
  assign fold_min   = (val_r < rd_min) ? val_r : rd_min;
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[IDX_W:1];
  assign mid_inc    = mid + IDX_W'(1);
  assign left_node  = {node_r[NODE_W-2:0], 1'b0};
  assign right_node = {node_r[NODE_W-2:0], 1'b1};
  assign disjoint   = (r_r < lo_r) || (l_r > hi_r);
  assign covered    = (l_r <= lo_r) && (r_r >= hi_r);
  assign sp_dec     = sp_r - SP_W'(1);
  assign top_frame  = stk_r[sp_dec[STK_AW-1:0]];
  assign clearing   = state_r == B_CLEAR;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    node_nxt      = node_r;
    val_nxt       = val_r;
    pend_nxt      = 1'b0;
    pend_node_nxt = pend_node_r;
    min_acc_nxt   = min_acc_r;
    max_acc_nxt   = max_acc_r;
    sp_nxt        = sp_r;
    push          = 1'b0;
    push_frame    = '{lo: mid_inc, hi: hi_r, node: right_node};
    out_valid_nxt = out_valid_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    cmd_ready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = pend_node_r;
    ram_wdata     = {fold_max, fold_min};
    ram_re        = 1'b0;
    ram_raddr     = node_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = {MAX_EMPTY, MIN_EMPTY};
        clr_addr_nxt = clr_addr_r + NODE_W'(1);
        if (clr_addr_r == NODE_W'(DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          lo_nxt      = IDX_W'(1);
          hi_nxt      = cmd.n;
          node_nxt    = NODE_W'(1);
          l_nxt       = cmd.first;
          r_nxt       = cmd.last;
          val_nxt     = cmd.value;
          min_acc_nxt = MIN_EMPTY;
          max_acc_nxt = MAX_EMPTY;
          sp_nxt      = '0;
          unique case (cmd.kind)
            CMD_LOAD:  state_nxt = B_LOAD;
            CMD_QUERY: state_nxt = B_QUERY;
            default:   state_nxt = B_OUT;
          endcase
        end
      end
      B_LOAD: begin
        // write back the node read last cycle while reading its child
        ram_we        = pend_r;
        ram_re        = 1'b1;
        pend_nxt      = 1'b1;
        pend_node_nxt = node_r;
        if (lo_r == hi_r) begin
          state_nxt = B_LOAD_END;
        end else if (l_r <= mid) begin
          hi_nxt   = mid;
          node_nxt = left_node;
        end else begin
          lo_nxt   = mid_inc;
          node_nxt = right_node;
        end
      end
      B_LOAD_END: begin
        ram_we    = 1'b1;
        state_nxt = B_IDLE;
      end
      B_QUERY: begin
        if (pend_r) begin
          min_acc_nxt = (rd_min < min_acc_r) ? rd_min : min_acc_r;
          max_acc_nxt = (rd_max > max_acc_r) ? rd_max : max_acc_r;
        end
        if (disjoint || covered) begin
          if (!disjoint) begin
            ram_re   = 1'b1;
            pend_nxt = 1'b1;
          end
          if (sp_r == '0) begin
            state_nxt = B_QDRAIN;
          end else begin
            lo_nxt   = top_frame.lo;
            hi_nxt   = top_frame.hi;
            node_nxt = top_frame.node;
            sp_nxt   = sp_dec;
          end
        end else begin
          // partial overlap: park the right child, descend left
          push     = 1'b1;
          sp_nxt   = sp_r + SP_W'(1);
          hi_nxt   = mid;
          node_nxt = left_node;
        end
      end
      B_QDRAIN: begin
        if (pend_r) begin
          min_acc_nxt = (rd_min < min_acc_r) ? rd_min : min_acc_r;
          max_acc_nxt = (rd_max > max_acc_r) ? rd_max : max_acc_r;
        end
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = min_acc_r;
          out_max_nxt   = max_acc_r;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    node_r      <= node_nxt;
    val_r       <= val_nxt;
    pend_node_r <= pend_node_nxt;
    min_acc_r   <= min_acc_nxt;
    max_acc_r   <= max_acc_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    if (push) begin
      stk_r[sp_r[STK_AW-1:0]] <= push_frame;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.range_min = out_min_r;
  assign out_chan.range_max = out_max_r;

  `ASSERT_CLK(a_stack_room, clk, rst_n, (push |-> sp_r < SP_W'(STACK_DEPTH)), "node stack overflow")
  `ASSERT_NEVER(a_idle_no_pend, clk, rst_n, (state_r == B_IDLE && pend_r), "read in flight at idle")
  `ASSERT_CLK(a_pend_from_read, clk, rst_n, (pend_r |-> $past(ram_re)), "pending data without read")

endmodule
`default_nettype wire

FILE: hw/rtl/range_min_max_tree.sv
// Top level of the range min/max tree: config register, front end, command
// queue and tree engine. Depends on rmm_pkg, rmm_if and the rmm_* modules.
//
//   channel   | direction | payload                                    
//   ----------+-----------+--------------------------------------------
//   in_chan   | in        | mode, first_index, last_index, value
//   out_chan  | out       | range_min, range_max (one per query)
//   cfg_chan  | in        | data = item_count, always ready
//
// After reset the engine clears all 4*MAX_ITEMS node RAM words, with
// in_chan.ready low. A load reads one node per tree level, from root to
// leaf (ceil(log2 n)+1 levels), and writes each back folded with the value;
// a query visits up to about four nodes a level, and an empty query none.
// The engine visits one node per cycle through the single read port of the
// node RAM. The two-entry queue keeps the front accepting, until it fills,
// while the engine works or a result waits in the output register.
`default_nettype none
module range_min_max_tree #(
  parameter int MAX_ITEMS = rmm_pkg::MAX_ITEMS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmm_in_if.sink     in_chan,
  rmm_out_if.source  out_chan,
  rmm_cfg_if.sink    cfg_chan
);
  import rmm_pkg::*;

  logic [IDX_W-1:0] item_count_r, item_count_nxt;
  logic             clearing;
  logic             push_valid, push_ready;
  cmd_t             push_cmd;
  logic             pop_valid, pop_ready;
  cmd_t             pop_cmd;

  assign cfg_chan.ready = 1'b1;
  assign item_count_nxt = (cfg_chan.valid && cfg_chan.ready) ? cfg_chan.data : item_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= ITEM_COUNT_RST;
    end else begin
      item_count_r <= item_count_nxt;
    end
  end

  rmm_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .item_count (item_count_r),
    .clearing   (clearing),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  rmm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_cmd),
    .pop_ready  (pop_ready)
  );

  rmm_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_ready (pop_ready),
    .clearing  (clearing),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire
